>>> rtl/wsdf_pkg.sv
package wsdf_pkg;

    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // one result beat as produced by the parser
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic [7:0] frame_header;
        logic       last_of_frame;
        logic       too_long_error;
    } wsdf_result_t;

endpackage

>>> rtl/wsdf_parser.sv
module wsdf_parser (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    byte_valid,
    input  logic [7:0]              rx_byte,
    output logic                    res_valid,
    output wsdf_pkg::wsdf_result_t  res
);
    import wsdf_pkg::*;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_EXT_HI  = 3'd2;
    localparam logic [2:0] PH_EXT_LO  = 3'd3;
    localparam logic [2:0] PH_MASK    = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_HALTED  = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  header_reg, header_next;
    logic        masked_reg, masked_next;
    logic [15:0] remain_reg, remain_next;
    logic [1:0]  keypos_reg, keypos_next;
    logic [7:0]  key_reg [4];
    logic        key_we;
    logic [6:0]  len_code;
    logic [15:0] remain_dec;

    assign len_code   = rx_byte[6:0];
    assign remain_dec = remain_reg - 16'd1;

    always_comb begin
        phase_next  = phase_reg;
        header_next = header_reg;
        masked_next = masked_reg;
        remain_next = remain_reg;
        keypos_next = keypos_reg;
        key_we      = 1'b0;
        res_valid   = 1'b0;
        res.data_byte      = 8'd0;
        res.has_data       = 1'b0;
        res.frame_header   = header_reg;
        res.last_of_frame  = 1'b0;
        res.too_long_error = 1'b0;

        unique case (phase_reg)
            PH_HEADER: begin
                header_next = rx_byte;
                masked_next = 1'b0;
                remain_next = 16'd0;
                keypos_next = 2'd0;
                phase_next  = PH_LENGTH;
            end
            PH_LENGTH: begin
                masked_next = rx_byte[7];
                if (len_code == LEN_CODE_EXT64) begin
                    phase_next         = PH_HALTED;
                    res_valid          = 1'b1;
                    res.too_long_error = 1'b1;
                end else if (len_code == LEN_CODE_EXT16) begin
                    phase_next = PH_EXT_HI;
                end else begin
                    remain_next = {9'd0, len_code};
                    keypos_next = 2'd0;
                    if (rx_byte[7]) begin
                        phase_next = PH_MASK;
                    end else if (len_code == 7'd0) begin
                        phase_next        = PH_HEADER;
                        res_valid         = 1'b1;
                        res.last_of_frame = 1'b1;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_EXT_HI: begin
                remain_next = {rx_byte, 8'd0};
                phase_next  = PH_EXT_LO;
            end
            PH_EXT_LO: begin
                remain_next = remain_reg | {8'd0, rx_byte};
                keypos_next = 2'd0;
                if (masked_reg) begin
                    phase_next = PH_MASK;
                end else if ((remain_reg | {8'd0, rx_byte}) == 16'd0) begin
                    phase_next        = PH_HEADER;
                    res_valid         = 1'b1;
                    res.last_of_frame = 1'b1;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_MASK: begin
                key_we = 1'b1;
                if (keypos_reg != 2'd3) begin
                    keypos_next = keypos_reg + 2'd1;
                end else begin
                    keypos_next = 2'd0;
                    if (remain_reg == 16'd0) begin
                        phase_next        = PH_HEADER;
                        res_valid         = 1'b1;
                        res.last_of_frame = 1'b1;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                res_valid         = 1'b1;
                res.has_data      = 1'b1;
                res.data_byte     = masked_reg ? (rx_byte ^ key_reg[keypos_reg]) : rx_byte;
                keypos_next       = keypos_reg + 2'd1;
                remain_next       = remain_dec;
                res.last_of_frame = (remain_dec == 16'd0);
                if (remain_dec == 16'd0) begin
                    phase_next = PH_HEADER;
                end
            end
            default: begin
                phase_next = PH_HALTED;
            end
        endcase

        if (!byte_valid) begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            header_reg <= 8'd0;
            masked_reg <= 1'b0;
            remain_reg <= 16'd0;
            keypos_reg <= 2'd0;
        end else if (byte_valid) begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            masked_reg <= masked_next;
            remain_reg <= remain_next;
            keypos_reg <= keypos_next;
        end
    end

    // mask key: no reset, only read after the four key bytes of this frame
    always_ff @(posedge aclk) begin
        if (byte_valid && key_we) begin
            key_reg[keypos_reg] <= rx_byte;
        end
    end

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HALTED) |=> (phase_reg == PH_HALTED))
        else $error("parser left halted state");

    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HALTED) |-> !res_valid)
        else $error("result produced while halted");

    a_payload_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (remain_reg != 16'd0))
        else $error("payload phase with zero remaining count");

endmodule

>>> rtl/websocket_frame_deframer_top.sv
// WebSocket frame deframer. Feed the received byte stream one byte per beat on
// the s_ channel; header, length, extended-length and mask-key bytes are absorbed
// and produce nothing, and every payload byte comes out on the m_ channel unmasked,
// with tlast on the final byte of its frame. A zero-length frame yields one beat
// with tuser.has_data low and tlast high. Length code 127 (64-bit length) yields
// one beat with tuser.too_long_error set; the block then swallows all further
// bytes until reset. Rate: one byte per clock while s_tready is high; each result
// is registered in the output register or skid entry. The parser decodes each byte
// combinationally, and a two-entry output register (main plus skid) lets input continue
// while a result waits on m_tready; s_tready drops only when both entries are full.
module websocket_frame_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [15:8] frame_header
    output logic        m_tlast,   // last_of_frame
    output logic [1:0]  m_tuser    // [0] has_data, [1] too_long_error
);
    import wsdf_pkg::*;

    logic         s_beat;
    logic         res_valid;
    wsdf_result_t res;

    // output register and skid entry
    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    wsdf_result_t out_reg, out_next;
    wsdf_result_t skid_reg, skid_next;
    logic         m_beat;
    logic         push;

    assign s_tready = !skid_valid_reg;
    assign s_beat   = s_tvalid && s_tready;

    wsdf_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_beat),
        .rx_byte    (s_tdata),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign push   = res_valid;
    assign m_beat = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (m_beat) begin
            if (skid_valid_reg) begin
                // skid moves up; a new result takes the freed skid slot
                out_next        = skid_reg;
                skid_valid_next = push;
                skid_next       = res;
            end else begin
                out_valid_next = push;
                out_next       = res;
            end
        end else if (push) begin
            if (!out_valid_reg) begin
                out_valid_next = 1'b1;
                out_next       = res;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.frame_header, out_reg.data_byte};
    assign m_tlast  = out_reg.last_of_frame;
    assign m_tuser  = {out_reg.too_long_error, out_reg.has_data};

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    a_drain_keeps_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && skid_valid_reg && m_tready) |=> out_valid_reg)
        else $error("skid entry lost on drain");

    a_error_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && !m_tlast && m_tdata[7:0] == 8'd0))
        else $error("error beat carries data or last");

    a_empty_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == 8'd0))
        else $error("data byte nonzero without has_data");

endmodule

>>> bench/tb_top.sv
module tb_top;
    import wsdf_pkg::*;

    localparam int HOLD_CYCLES  = 300;     // long m_tready hold-off
    localparam int DRAIN_CYCLES = 20;      // quiet cycles before the verdict
    localparam int LIMIT_CYCLES = 200000;  // watchdog
    localparam int IDLE_HEAVY   = 63;      // percent
    localparam int IDLE_LIGHT   = 10;      // percent

    localparam wsdf_result_t NO_BEAT = '0;

    // parser phases, mirrored from the frame layout
    typedef enum logic [2:0] {
        AWAIT_HDR,
        AWAIT_LEN,
        AWAIT_EXT_HI,
        AWAIT_EXT_LO,
        AWAIT_KEY,
        IN_PAYLOAD,
        STOPPED
    } parse_phase_t;

    // one row of the directed table
    typedef struct packed {
        logic [7:0]   rx;
        logic         typed;   // expectation written in the row, not predicted
        logic         gives;   // typed row: a result beat is due
        wsdf_result_t want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] data_byte, [15:8] frame_header
    logic        m_tlast;   // last_of_frame
    logic [1:0]  m_tuser;   // [0] has_data, [1] too_long_error

    websocket_frame_deframer_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // shadow parser state
    parse_phase_t phase_q  = AWAIT_HDR;
    logic [7:0]   hdr_q    = '0;
    logic         masked_q = 1'b0;
    logic [15:0]  remain_q = '0;
    logic [7:0]   key_q [4];
    logic [1:0]   kpos_q   = '0;

    wsdf_result_t frame_beats [$];   // unmasked beats still owed by the block
    int           mismatches  = 0;
    int           sent        = 0;
    int           snd_idle_pct = 0;
    int           rcv_stall_pct = 0;
    int           hold_asks   = 0;
    int           hold_done   = 0;
    int           hold_left   = 0;
    int           cycles      = 0;

    // Directed part. Typed expectations where they are obvious; the masked
    // three-byte frame at the end goes through the shadow parser.
    stim_row_t dir_rows [25] = '{
        // zero-length frame, unmasked
        '{8'h81, 1'b1, 1'b0, NO_BEAT},
        '{8'h00, 1'b1, 1'b1, {8'h00, 1'b0, 8'h81, 1'b1, 1'b0}},
        // zero-length frame, masked: beat comes after the fourth key byte
        '{8'hFF, 1'b1, 1'b0, NO_BEAT},
        '{8'h80, 1'b1, 1'b0, NO_BEAT},
        '{8'h00, 1'b1, 1'b0, NO_BEAT},
        '{8'hFF, 1'b1, 1'b0, NO_BEAT},
        '{8'hAA, 1'b1, 1'b0, NO_BEAT},
        '{8'h55, 1'b1, 1'b1, {8'h00, 1'b0, 8'hFF, 1'b1, 1'b0}},
        // two payload bytes, unmasked, data extremes
        '{8'h00, 1'b1, 1'b0, NO_BEAT},
        '{8'h02, 1'b1, 1'b0, NO_BEAT},
        '{8'hFF, 1'b1, 1'b1, {8'hFF, 1'b1, 8'h00, 1'b0, 1'b0}},
        '{8'h00, 1'b1, 1'b1, {8'h00, 1'b1, 8'h00, 1'b1, 1'b0}},
        // 16-bit extended length of zero
        '{8'h82, 1'b1, 1'b0, NO_BEAT},
        '{8'h7E, 1'b1, 1'b0, NO_BEAT},
        '{8'h00, 1'b1, 1'b0, NO_BEAT},
        '{8'h00, 1'b1, 1'b1, {8'h00, 1'b0, 8'h82, 1'b1, 1'b0}},
        // masked three-byte frame
        '{8'h01, 1'b0, 1'b0, NO_BEAT},
        '{8'h83, 1'b0, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b0, NO_BEAT},
        '{8'h0F, 1'b0, 1'b0, NO_BEAT},
        '{8'hF0, 1'b0, 1'b0, NO_BEAT},
        '{8'h5A, 1'b0, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b0, NO_BEAT}
    };

    // 64-bit length code (mask bit set too): error beat, then the block
    // swallows everything. Only usable once, at the very end.
    stim_row_t halt_rows [5] = '{
        '{8'h88, 1'b1, 1'b0, NO_BEAT},
        '{8'hFF, 1'b1, 1'b1, {8'h00, 1'b0, 8'h88, 1'b0, 1'b1}},
        '{8'h81, 1'b1, 1'b0, NO_BEAT},
        '{8'h05, 1'b1, 1'b0, NO_BEAT},
        '{8'hAA, 1'b1, 1'b0, NO_BEAT}
    };

    // 4-unit clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Length and key are in: emit the empty-frame beat or go to payload.
    function automatic bit header_done(output wsdf_result_t r);
        r = '0;
        kpos_q = '0;
        if (remain_q == 16'd0) begin
            phase_q = AWAIT_HDR;
            r.frame_header  = hdr_q;
            r.last_of_frame = 1'b1;
            return 1'b1;
        end
        phase_q = IN_PAYLOAD;
        return 1'b0;
    endfunction

    // Shadow parser: one received byte in, maybe one beat out.
    function automatic bit parse_byte(input logic [7:0] b, output wsdf_result_t r);
        logic [7:0] d;
        r = '0;
        case (phase_q)
            AWAIT_HDR: begin
                hdr_q    = b;
                masked_q = 1'b0;
                remain_q = '0;
                kpos_q   = '0;
                phase_q  = AWAIT_LEN;
                return 1'b0;
            end
            AWAIT_LEN: begin
                masked_q = b[7];
                if (b[6:0] == LEN_CODE_EXT64) begin
                    phase_q = STOPPED;
                    r.frame_header   = hdr_q;
                    r.too_long_error = 1'b1;
                    return 1'b1;
                end
                if (b[6:0] == LEN_CODE_EXT16) begin
                    phase_q = AWAIT_EXT_HI;
                    return 1'b0;
                end
                remain_q = {9'd0, b[6:0]};
                if (masked_q) begin
                    kpos_q  = '0;
                    phase_q = AWAIT_KEY;
                    return 1'b0;
                end
                return header_done(r);
            end
            AWAIT_EXT_HI: begin
                remain_q = {b, 8'h00};
                phase_q  = AWAIT_EXT_LO;
                return 1'b0;
            end
            AWAIT_EXT_LO: begin
                remain_q[7:0] = b;
                if (masked_q) begin
                    kpos_q  = '0;
                    phase_q = AWAIT_KEY;
                    return 1'b0;
                end
                return header_done(r);
            end
            AWAIT_KEY: begin
                key_q[kpos_q] = b;
                if (kpos_q != 2'd3) begin
                    kpos_q = kpos_q + 2'd1;
                    return 1'b0;
                end
                return header_done(r);
            end
            IN_PAYLOAD: begin
                d = masked_q ? (b ^ key_q[kpos_q]) : b;
                kpos_q   = kpos_q + 2'd1;
                remain_q = remain_q - 16'd1;
                r.data_byte     = d;
                r.has_data      = 1'b1;
                r.frame_header  = hdr_q;
                r.last_of_frame = (remain_q == 16'd0);
                if (remain_q == 16'd0)
                    phase_q = AWAIT_HDR;
                return 1'b1;
            end
            default: return 1'b0;   // halted
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Offer one byte; random idle cycles first. On acceptance, predict.
    task automatic send_row(input stim_row_t row);
        wsdf_result_t r;
        bit           due;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.rx;
        do @(posedge aclk); while (!s_tready);
        due = parse_byte(row.rx, r);
        if (row.typed) begin
            due = row.gives;
            r   = row.want;
        end
        if (due)
            frame_beats.push_back(r);
        sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_row('{b, 1'b0, 1'b0, NO_BEAT});
    endtask

    // One well-formed frame with random header, mask, key and payload.
    // Lengths are mostly short; the long one crosses 256 to use the high
    // extended-length byte.
    task automatic random_frame(input bit long_one);
        logic [7:0]  hdr;
        logic [6:0]  code;
        logic [15:0] len;
        bit          use_mask;
        int          pick;
        hdr      = 8'($urandom_range(255));
        use_mask = 1'($urandom_range(1));
        pick     = $urandom_range(99);
        if (long_one) begin
            code = LEN_CODE_EXT16;
            len  = 16'h0100 + 16'($urandom_range(15));
        end else if (pick < 8) begin
            code = 7'd0;
            len  = 16'd0;
        end else if (pick < 11) begin
            code = 7'd125;
            len  = 16'd125;
        end else if (pick < 30) begin
            code = LEN_CODE_EXT16;
            len  = 16'($urandom_range(40));
        end else begin
            len  = 16'($urandom_range(24, 1));
            code = len[6:0];
        end
        send_byte(hdr);
        send_byte({use_mask, code});
        if (code == LEN_CODE_EXT16) begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        if (use_mask)
            repeat (4) send_byte(8'($urandom_range(255)));
        repeat (len) send_byte(8'($urandom_range(255)));
    endtask

    // Sender goes quiet until every owed beat is back.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (frame_beats.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
    endtask

    // Receiver: random stalls, plus the long hold-off when asked for.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_asks != hold_done) begin
                hold_done++;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    // Result checker: every accepted beat against the oldest owed one.
    always @(posedge aclk) begin
        wsdf_result_t want;
        wsdf_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.data_byte      = m_tdata[7:0];
            got.frame_header   = m_tdata[15:8];
            got.has_data       = m_tuser[0];
            got.too_long_error = m_tuser[1];
            got.last_of_frame  = m_tlast;
            if (frame_beats.size() == 0) begin
                $error("unexpected result beat: tdata %0h tlast %0b tuser %0h",
                       m_tdata, m_tlast, m_tuser);
                mismatches++;
            end else begin
                want = frame_beats.pop_front();
                check_field("data_byte", want.data_byte, got.data_byte);
                check_field("has_data", 8'(want.has_data), 8'(got.has_data));
                check_field("frame_header", want.frame_header, got.frame_header);
                check_field("last_of_frame", 8'(want.last_of_frame),
                            8'(got.last_of_frame));
                check_field("too_long_error", 8'(want.too_long_error),
                            8'(got.too_long_error));
            end
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, no idling
        foreach (dir_rows[n])
            send_row(dir_rows[n]);

        // random, no idling
        while (sent < 100)
            random_frame(1'b0);
        quiesce();

        // long receiver hold-off while a long frame streams in: fills the
        // output stage and backs up s_tready
        hold_asks++;
        random_frame(1'b1);

        snd_idle_pct = IDLE_HEAVY;
        while (sent < 470)
            random_frame(1'b0);
        quiesce();

        snd_idle_pct  = 0;
        rcv_stall_pct = IDLE_HEAVY;
        while (sent < 560)
            random_frame(1'b0);
        quiesce();

        snd_idle_pct  = IDLE_LIGHT;
        rcv_stall_pct = IDLE_LIGHT;
        while (sent < 630)
            random_frame(1'b0);
        quiesce();

        // too-long frame halts the parser for good, so it goes last
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        foreach (halt_rows[n])
            send_row(halt_rows[n]);
        quiesce();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
